// ===== rtl/core/text_console_writer_core_macros.svh =====
// Assertion macros for the checker file of the text console core.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define TXC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("text console check failed");

// Next-cycle implication, disabled while rst is high.
`define TXC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("text console check failed");

`endif

// ===== rtl/core/txc_pkg.sv =====
package txc_pkg;

   // Screen geometry.
   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;
   localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int CELL_AW        = $clog2(CELL_COUNT);
   localparam int CNT_W          = $clog2(CELL_COUNT + 1);
   localparam int LAST_ROW_BASE  = CELL_COUNT - SCREEN_COLUMNS;

   // Field widths.
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int OFS_W  = 11;
   localparam int CHAR_W = 8;
   localparam int CELL_W = 16;
   localparam int OP_W   = 2;

   localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(SCREEN_COLUMNS);
   localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);

   // Character and attribute codes.
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] CLEAR_ATTR   = 8'h0F;
   localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'h0F;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'h0D;

   // Operation codes on the request port.
   localparam logic [OP_W-1:0] OP_PUT       = 2'd0;
   localparam logic [OP_W-1:0] OP_BACKSPACE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;
   localparam logic [OP_W-1:0] OP_READ      = 2'd3;

   // Register port.
   localparam int PADDR_W = 2;
   localparam int PDATA_W = 32;
   localparam logic [PADDR_W-1:0] REG_TEXT_ATTR = 2'd0;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_PUT,
      CMD_NEWLINE,
      CMD_RETURN,
      CMD_BACKSPACE,
      CMD_CLEAR,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic [CHAR_W-1:0]        ch;
      logic                     rd_valid;
      logic [CELL_AW-1:0]       rd_addr;
   } cmd_type;

   // Linear cell offset of a row and column.
   function automatic logic [CNT_W-1:0] calc_offset(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
      return CNT_W'(row) * CNT_W'(SCREEN_COLUMNS) + CNT_W'(col);
   endfunction

endpackage

// ===== rtl/core/txc_ram.sv =====
module txc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/txc_front.sv =====
module txc_front (
   input  logic                         start,
   input  logic [txc_pkg::OP_W-1:0]     req_operation,
   input  logic [txc_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [txc_pkg::ROW_W-1:0]    req_read_row,
   input  logic [txc_pkg::COL_W-1:0]    req_read_col,
   input  logic                         q_full,
   input  logic                         init_busy,
   output logic                         busy,
   output logic                         push,
   output txc_pkg::cmd_type             cmd
);
   import txc_pkg::*;

   logic [CNT_W-1:0] rd_ofs;

   assign busy   = q_full | init_busy;
   assign push   = start & ~busy;
   assign rd_ofs = calc_offset(req_read_row, req_read_col);

   // Split put into its three flavors so the back sees one command per action.
   always_comb begin
      cmd.ch       = req_char_code;
      cmd.rd_valid = (CNT_W'(req_read_row) < CNT_W'(SCREEN_ROWS)) &&
                     (CNT_W'(req_read_col) < CNT_W'(SCREEN_COLUMNS));
      cmd.rd_addr  = rd_ofs[CELL_AW-1:0];
      case (req_operation)
         OP_PUT: begin
            if (req_char_code == CHAR_NEWLINE) begin
               cmd.kind = CMD_NEWLINE;
            end else if (req_char_code == CHAR_RETURN) begin
               cmd.kind = CMD_RETURN;
            end else begin
               cmd.kind = CMD_PUT;
            end
         end
         OP_BACKSPACE: cmd.kind = CMD_BACKSPACE;
         OP_CLEAR:     cmd.kind = CMD_CLEAR;
         OP_READ:      cmd.kind = CMD_READ;
         default:      cmd.kind = CMD_READ;
      endcase
   end

endmodule

// ===== rtl/core/txc_queue.sv =====
module txc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  txc_pkg::cmd_type push_cmd,
   input  logic             pop,
   output txc_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);
   import txc_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/txc_back.sv =====
module txc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  txc_pkg::cmd_type             q_head,
   output logic                         q_pop,
   input  logic [txc_pkg::CHAR_W-1:0]   text_attr,
   output logic                         init_busy,
   output logic                         rsp_strobe,
   output logic [txc_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic [txc_pkg::COL_W-1:0]    rsp_cursor_col,
   output logic [txc_pkg::OFS_W-1:0]    rsp_cursor_offset,
   output logic [txc_pkg::CHAR_W-1:0]   rsp_cell_char,
   output logic [txc_pkg::CHAR_W-1:0]   rsp_cell_attr
);
   import txc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PUT    = 5'b00010,
      ST_READ   = 5'b00100,
      ST_SCROLL = 5'b01000,
      ST_SWEEP  = 5'b10000
   } state_type;

   // What follows a fill of blanks.
   typedef enum logic [1:0] {
      FOLLOW_NONE,
      FOLLOW_EMIT,
      FOLLOW_PUT
   } follow_type;

   state_type           state_ff, state_in;
   follow_type          follow_ff, follow_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [CHAR_W-1:0]   put_char_ff, put_char_in;
   logic                put_adv_ff, put_adv_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                cp_valid_ff, cp_valid_in;
   logic [CELL_AW-1:0]  cp_addr_ff, cp_addr_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic [COL_W-1:0]    rsp_col_ff;
   logic [OFS_W-1:0]    rsp_ofs_ff;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [CHAR_W-1:0]   rsp_attr_ff, rsp_attr_in;

   logic                ram_we;
   logic [CELL_AW-1:0]  ram_waddr, ram_raddr;
   logic [CELL_W-1:0]   ram_wdata, ram_rdata;
   logic [CNT_W-1:0]    cur_ofs, next_ofs, src_back;

   txc_ram #(
      .WIDTH(CELL_W),
      .DEPTH(CELL_COUNT)
   ) u_screen (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign cur_ofs   = calc_offset(row_ff, col_ff);
   assign next_ofs  = calc_offset(row_in, col_in);
   assign src_back  = cnt_ff - CNT_W'(SCREEN_COLUMNS);
   assign init_busy = (state_ff == ST_SWEEP) && (follow_ff == FOLLOW_NONE);

   always_comb begin
      state_in      = state_ff;
      follow_in     = follow_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      put_char_in   = put_char_ff;
      put_adv_in    = put_adv_ff;
      cnt_in        = cnt_ff;
      cp_valid_in   = 1'b0;
      cp_addr_in    = cp_addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_char_in   = '0;
      rsp_attr_in   = '0;
      q_pop         = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = cnt_ff[CELL_AW-1:0];
      ram_wdata     = {CLEAR_ATTR, BLANK_CHAR};
      ram_raddr     = cnt_ff[CELL_AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               case (q_head.kind)
                  CMD_PUT: begin
                     put_char_in = q_head.ch;
                     put_adv_in  = 1'b1;
                     state_in    = ST_PUT;
                     if (col_ff >= COL_LIMIT) begin
                        col_in = '0;
                        if (row_ff < ROW_LAST) begin
                           row_in = row_ff + 1'b1;
                        end else begin
                           cnt_in    = CNT_W'(SCREEN_COLUMNS);
                           follow_in = FOLLOW_PUT;
                           state_in  = ST_SCROLL;
                        end
                     end
                  end
                  CMD_NEWLINE: begin
                     col_in = '0;
                     if (row_ff < ROW_LAST) begin
                        row_in        = row_ff + 1'b1;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        cnt_in    = CNT_W'(SCREEN_COLUMNS);
                        follow_in = FOLLOW_EMIT;
                        state_in  = ST_SCROLL;
                     end
                  end
                  CMD_RETURN: begin
                     col_in        = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  CMD_BACKSPACE: begin
                     if (col_ff != '0) begin
                        col_in      = col_ff - 1'b1;
                        put_char_in = BLANK_CHAR;
                        put_adv_in  = 1'b0;
                        state_in    = ST_PUT;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     row_in    = '0;
                     col_in    = '0;
                     cnt_in    = '0;
                     follow_in = FOLLOW_EMIT;
                     state_in  = ST_SWEEP;
                  end
                  CMD_READ: begin
                     if (q_head.rd_valid) begin
                        ram_raddr = q_head.rd_addr;
                        state_in  = ST_READ;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = cur_ofs[CELL_AW-1:0];
            ram_wdata = {text_attr, put_char_ff};
            if (put_adv_ff) begin
               col_in = col_ff + 1'b1;
            end
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_READ: begin
            rsp_char_in   = ram_rdata[CHAR_W-1:0];
            rsp_attr_in   = ram_rdata[CELL_W-1:CHAR_W];
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SCROLL: begin
            // Read one row ahead, write the word back one row up next cycle.
            if (cnt_ff < CNT_W'(CELL_COUNT)) begin
               cnt_in      = cnt_ff + 1'b1;
               cp_valid_in = 1'b1;
               cp_addr_in  = src_back[CELL_AW-1:0];
            end
            if (cp_valid_ff) begin
               ram_we    = 1'b1;
               ram_waddr = cp_addr_ff;
               ram_wdata = ram_rdata;
            end
            if ((cnt_ff == CNT_W'(CELL_COUNT)) && !cp_valid_ff) begin
               cnt_in   = CNT_W'(LAST_ROW_BASE);
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            ram_we = 1'b1;
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               case (follow_ff)
                  FOLLOW_EMIT: begin
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end
                  FOLLOW_PUT: state_in = ST_PUT;
                  default:    state_in = ST_IDLE;
               endcase
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         follow_ff     <= FOLLOW_NONE;
         row_ff        <= '0;
         col_ff        <= '0;
         cnt_ff        <= '0;
         cp_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         follow_ff     <= follow_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         cnt_ff        <= cnt_in;
         cp_valid_ff   <= cp_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      put_char_ff <= put_char_in;
      put_adv_ff  <= put_adv_in;
      cp_addr_ff  <= cp_addr_in;
      rsp_row_ff  <= row_in;
      rsp_col_ff  <= col_in;
      rsp_ofs_ff  <= next_ofs[OFS_W-1:0];
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_col    = rsp_col_ff;
   assign rsp_cursor_offset = rsp_ofs_ff;
   assign rsp_cell_char     = rsp_char_ff;
   assign rsp_cell_attr     = rsp_attr_ff;

endmodule

// ===== rtl/core/text_console_writer_core.sv =====
// Teletype text console over an 80 by 25 character-cell screen store. An operation
// is taken when start is high and busy is low; each one gives exactly one result,
// shown for a single cycle while rsp_strobe is high, and the receiver cannot stall
// it, so a result must be captured in that cycle. Results come in the order the
// operations were taken. A carriage return, a newline without scroll, a backspace at
// column zero and an out-of-range read finish in the back end's idle state; a
// character, a backspace and an in-range read also pass through a put or a read
// state. A newline or wrap on the bottom row scrolls the screen through the single
// read and single write port of the screen memory, one cell a cycle. Clear writes
// every cell once. After reset the same clearing pass runs and busy stays high
// throughout. A two-entry command queue lets two more operations be taken while
// the back end works; busy rises when it is full. text_attribute sits at byte
// address 0 of the register port and may be written only when no operation is
// outstanding.
module text_console_writer_core (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          start,
   output logic                          busy,
   input  logic [txc_pkg::OP_W-1:0]      req_operation,
   input  logic [txc_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [txc_pkg::ROW_W-1:0]     req_read_row,
   input  logic [txc_pkg::COL_W-1:0]     req_read_col,
   // Result channel.
   output logic                          rsp_strobe,
   output logic [txc_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [txc_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic [txc_pkg::OFS_W-1:0]     rsp_cursor_offset,
   output logic [txc_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic [txc_pkg::CHAR_W-1:0]    rsp_cell_attr,
   // Register port.
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [txc_pkg::PADDR_W-1:0]   paddr,
   input  logic [txc_pkg::PDATA_W-1:0]   pwdata,
   output logic [txc_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);
   import txc_pkg::*;

   logic [CHAR_W-1:0]   text_attr_ff, text_attr_in;
   logic                csr_write;
   logic                q_full, q_empty, q_push, q_pop, init_busy;
   cmd_type             push_cmd, head_cmd;

   // The register port never waits. A write lands at the edge that ends the access
   // phase; any address other than the attribute register is ignored.
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & (paddr == REG_TEXT_ATTR);

   always_comb begin
      text_attr_in = text_attr_ff;
      if (csr_write) begin
         text_attr_in = pwdata[CHAR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff <= ATTR_RESET;
      end else begin
         text_attr_ff <= text_attr_in;
      end
   end

   assign prdata = (paddr == REG_TEXT_ATTR) ? PDATA_W'(text_attr_ff) : '0;

   // The front end takes a transfer and turns it into one back-end command.
   txc_front u_front (
      .start        (start),
      .req_operation(req_operation),
      .req_char_code(req_char_code),
      .req_read_row (req_read_row),
      .req_read_col (req_read_col),
      .q_full       (q_full),
      .init_busy    (init_busy),
      .busy         (busy),
      .push         (q_push),
      .cmd          (push_cmd)
   );

   txc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_cmd(push_cmd),
      .pop     (q_pop),
      .head    (head_cmd),
      .empty   (q_empty),
      .full    (q_full)
   );

   // The back end owns the cursor and the screen memory and issues every result.
   txc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (head_cmd),
      .q_pop            (q_pop),
      .text_attr        (text_attr_ff),
      .init_busy        (init_busy),
      .rsp_strobe       (rsp_strobe),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_offset(rsp_cursor_offset),
      .rsp_cell_char    (rsp_cell_char),
      .rsp_cell_attr    (rsp_cell_attr)
   );

endmodule

// ===== rtl/core/txc_checker.sv =====
`include "text_console_writer_core_macros.svh"

module txc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic [txc_pkg::ROW_W-1:0]     rsp_cursor_row,
   input logic [txc_pkg::COL_W-1:0]     rsp_cursor_col,
   input logic [txc_pkg::OFS_W-1:0]     rsp_cursor_offset
);
   import txc_pkg::*;

   logic [CNT_W-1:0] exp_ofs;
   logic             ofs_match, cursor_in_range;

   assign exp_ofs         = calc_offset(rsp_cursor_row, rsp_cursor_col);
   assign ofs_match       = (rsp_cursor_offset == exp_ofs[OFS_W-1:0]);
   assign cursor_in_range = (rsp_cursor_row <= ROW_LAST) && (rsp_cursor_col <= COL_LIMIT);

   // The reported offset always agrees with the reported row and column.
   `TXC_ASSERT_IMP(a_offset_match, clock, reset, rsp_strobe, ofs_match)
   // The cursor never leaves the screen, a pending wrap aside.
   `TXC_ASSERT_IMP(a_cursor_range, clock, reset, rsp_strobe, cursor_in_range)
   // The clearing pass after reset holds off new transfers.
   `TXC_ASSERT_NXT(a_reset_busy, clock, 1'b0, reset, busy)
   // No result can come out of reset.
   `TXC_ASSERT_NXT(a_reset_quiet, clock, 1'b0, reset, !rsp_strobe)

endmodule

bind text_console_writer_core txc_checker u_txc_checker (
   .clock            (clock),
   .reset            (reset),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_cursor_row   (rsp_cursor_row),
   .rsp_cursor_col   (rsp_cursor_col),
   .rsp_cursor_offset(rsp_cursor_offset)
);
